FILE: hw/rtl/sle_pkg.sv
// Shared types, character codes and the echo sequence table of the serial line editor.
package sle_pkg;

  localparam int unsigned LEN_W   = 6;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned STEP_W  = 3;
  localparam int unsigned QDEPTH  = 4;

  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_NAK   = 8'h15;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_HIGH  = 8'h80;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [1:0] REASON_CR   = 2'd0;
  localparam logic [1:0] REASON_EOT  = 2'd1;
  localparam logic [1:0] REASON_FULL = 2'd2;

  localparam logic CMD_RECEIVE = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_RUB,
    OP_KILL,
    OP_NEWLINE,
    OP_EOT,
    OP_FULL,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       data;
    logic [LEN_W-1:0] length;
  } entry_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] reason;
    logic       last;
  } result_t;

  function automatic result_t step_result(op_t op, logic [7:0] data,
                                          logic [STEP_W-1:0] step);
    result_t r;
    r = '{kind: KIND_ECHO, data: 8'h00, reason: REASON_CR, last: 1'b0};
    unique case (op)
      OP_PRINT: begin
        r.data = data;
        r.last = 1'b1;
      end
      OP_READ: begin
        r.kind = KIND_READ;
        r.data = data;
        r.last = 1'b1;
      end
      OP_RUB: begin
        r.data = (step == 3'd1) ? CH_SPACE : CH_BS;
        r.last = (step == 3'd2);
      end
      OP_KILL: begin
        unique case (step)
          3'd0:    r.data = CH_CARET;
          3'd1:    r.data = CH_U;
          3'd2:    r.data = CH_CR;
          3'd3:    r.data = CH_LF;
          3'd4:    r.data = CH_GT;
          default: r.data = CH_SPACE;
        endcase
        r.last = (step == 3'd5);
      end
      OP_NEWLINE: begin
        unique case (step)
          3'd0:    r.data = CH_CR;
          3'd1:    r.data = CH_LF;
          default: begin
            r.kind   = KIND_DONE;
            r.reason = REASON_CR;
            r.last   = 1'b1;
          end
        endcase
      end
      OP_EOT: begin
        unique case (step)
          3'd0:    r.data = CH_CARET;
          3'd1:    r.data = CH_D;
          default: begin
            r.kind   = KIND_DONE;
            r.reason = REASON_EOT;
            r.last   = 1'b1;
          end
        endcase
      end
      OP_FULL: begin
        r.kind   = KIND_DONE;
        r.reason = REASON_FULL;
        r.last   = 1'b1;
      end
      default: r.last = 1'b1;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/sle_in_if.sv
// Input channel of the serial line editor: handshake and item fields.
interface sle_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [7:0]                    rx_byte;
  logic [sle_pkg::IDX_W-1:0]     read_index;

  modport source (output valid, command, rx_byte, read_index, input ready);
  modport sink   (input valid, command, rx_byte, read_index, output ready);
endinterface

FILE: hw/rtl/sle_out_if.sv
// Result channel of the serial line editor: handshake and result fields.
interface sle_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [7:0]                    data;
  logic [sle_pkg::LEN_W-1:0]     length;
  logic [1:0]                    end_reason;
  logic                          last;

  modport source (output valid, kind, data, length, end_reason, last, input ready);
  modport sink   (input valid, kind, data, length, end_reason, last, output ready);
endinterface

FILE: hw/rtl/sle_front.sv
// Front end: accepts bytes, updates the line state and store, and issues echo and read jobs.
module sle_front #(
  parameter int unsigned LINE_DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  sle_in_if.sink          in_ch,
  input  logic            q_full,
  output logic            push,
  output sle_pkg::entry_t push_entry
);

  localparam int unsigned AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic [7:0]            mem [LINE_DEPTH];
  logic [AW-1:0]         fill_r, fill_nxt, fc_eff;
  logic                  ended_r, ended_nxt;
  logic                  stage_v_r, stage_v_nxt;
  sle_pkg::entry_t       stage_r, stage_nxt;
  logic                  in_range_r;
  logic [7:0]            rd_r;
  logic                  accept;
  logic                  wr_en;
  logic                  produces;
  sle_pkg::op_t          op;
  logic [AW+sle_pkg::IDX_W-1:0] idx_ext;
  logic [AW+sle_pkg::LEN_W-1:0] len_ext;
  logic [7:0]            c;

  assign in_ch.ready = !stage_v_r || !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = stage_v_r && !q_full;
  assign fc_eff      = ended_r ? '0 : fill_r;
  assign c           = in_ch.rx_byte;
  assign idx_ext     = {{AW{1'b0}}, in_ch.read_index};
  assign len_ext     = {{sle_pkg::LEN_W{1'b0}}, fill_nxt};

  always_comb begin
    fill_nxt  = fill_r;
    ended_nxt = ended_r;
    wr_en     = 1'b0;
    produces  = 1'b0;
    op        = sle_pkg::OP_READ;
    if (accept) begin
      if (in_ch.command == sle_pkg::CMD_READ) begin
        produces = 1'b1;
      end else begin
        fill_nxt  = fc_eff;
        ended_nxt = 1'b0;
        priority if (fc_eff == AW'(LINE_DEPTH - 1)) begin
          ended_nxt = 1'b1;
          op        = sle_pkg::OP_FULL;
          produces  = 1'b1;
        end else if (c == sle_pkg::CH_EOT) begin
          ended_nxt = 1'b1;
          op        = sle_pkg::OP_EOT;
          produces  = 1'b1;
        end else if (c == sle_pkg::CH_DEL || c == sle_pkg::CH_BS) begin
          if (fc_eff != '0) begin
            fill_nxt = fc_eff - AW'(1);
            op       = sle_pkg::OP_RUB;
            produces = 1'b1;
          end
        end else if (c == sle_pkg::CH_NAK) begin
          fill_nxt = '0;
          op       = sle_pkg::OP_KILL;
          produces = 1'b1;
        end else if (c == sle_pkg::CH_CR) begin
          ended_nxt = 1'b1;
          op        = sle_pkg::OP_NEWLINE;
          produces  = 1'b1;
        end else if (c >= sle_pkg::CH_SPACE && c < sle_pkg::CH_HIGH) begin
          fill_nxt = fc_eff + AW'(1);
          wr_en    = 1'b1;
          op       = sle_pkg::OP_PRINT;
          produces = 1'b1;
        end
      end
    end
  end

  always_comb begin
    stage_v_nxt = stage_v_r;
    stage_nxt   = stage_r;
    if (accept) begin
      stage_v_nxt = produces;
      stage_nxt   = '{op: op, data: c, length: len_ext[sle_pkg::LEN_W-1:0]};
    end else if (push) begin
      stage_v_nxt = 1'b0;
    end
  end

  always_comb begin
    push_entry = stage_r;
    if (stage_r.op == sle_pkg::OP_READ) begin
      push_entry.data = in_range_r ? rd_r : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      ended_r   <= 1'b0;
      stage_v_r <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      ended_r   <= ended_nxt;
      stage_v_r <= stage_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
    if (accept) begin
      rd_r       <= mem[idx_ext[AW-1:0]];
      in_range_r <= ({3'b000, in_ch.read_index} < 9'(LINE_DEPTH));
    end
    if (wr_en) begin
      mem[fc_eff] <= c;
    end
  end

endmodule

FILE: hw/rtl/sle_queue.sv
// Short job queue between the front end and the echo sequencer.
module sle_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sle_pkg::entry_t push_entry,
  input  logic            pop,
  output sle_pkg::entry_t head,
  output logic            empty,
  output logic            full
);

  localparam int unsigned PW = $clog2(sle_pkg::QDEPTH);

  sle_pkg::entry_t  slots_r [sle_pkg::QDEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [PW:0]      cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (PW+1)'(sle_pkg::QDEPTH));
  assign head  = slots_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (PW+1)'(1);
        2'b01:   cnt_r <= cnt_r - (PW+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wp_r] <= push_entry;
    end
  end

endmodule

FILE: hw/rtl/sle_back.sv
// Back end: steps through each job's echo sequence into the result register.
module sle_back (
  input  logic            clk,
  input  logic            rst_n,
  input  sle_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  sle_out_if.source       out_ch
);

  logic [sle_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                       valid_r, valid_nxt;
  sle_pkg::result_t           res;
  logic                       load;
  logic [1:0]                 kind_r;
  logic [7:0]                 data_r;
  logic [sle_pkg::LEN_W-1:0]  length_r;
  logic [1:0]                 reason_r;
  logic                       last_r;

  assign res  = sle_pkg::step_result(head.op, head.data, step_r);
  assign load = !empty && (!valid_r || out_ch.ready);
  assign pop  = load && res.last;

  always_comb begin
    step_nxt  = step_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
      step_nxt  = res.last ? '0 : step_r + sle_pkg::STEP_W'(1);
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r  <= step_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r   <= res.kind;
      data_r   <= res.data;
      length_r <= head.length;
      reason_r <= res.reason;
      last_r   <= res.last;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.data       = data_r;
  assign out_ch.length     = length_r;
  assign out_ch.end_reason = reason_r;
  assign out_ch.last       = last_r;

endmodule

FILE: hw/rtl/serial_line_editor_top.sv
// Items pass the stage register and a queue slot before reaching the result register.
// One byte per cycle enters while the four-entry job queue has room; the echo sequencer
// gives one result per cycle while the output is ready, up to six results per item.
// Reset (synchronous, active low) empties the line, the queue and the result register;
// the line store is not cleared and holds unknown data until written.
module serial_line_editor_top #(
  parameter int unsigned LINE_DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  sle_in_if.sink    in_ch,
  sle_out_if.source out_ch
);

  logic            push, pop, q_empty, q_full;
  sle_pkg::entry_t push_entry, head;

  sle_front #(.LINE_DEPTH(LINE_DEPTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  sle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  sle_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
